### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/rfid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfid_pkg
// Types and byte codes for the ASCII hex tag frame parser.
// ----------------------------------------------------------------------------
package rfid_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_HOLD    = 3'b100
    } t_phase;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_STX = 8'h02;

    localparam logic [7:0] ASC_0 = 8'h30;
    localparam logic [7:0] ASC_9 = 8'h39;
    localparam logic [7:0] ASC_A = 8'h41;
    localparam logic [7:0] ASC_F = 8'h46;

    localparam int unsigned TAG_BYTES    = 6;
    localparam logic [3:0]  FRAME_DIGITS = 4'd12;
    localparam logic [2:0]  CHECK_INDEX  = 3'd5;

endpackage
`default_nettype wire

### hw/rtl/rfid_ascii_hex_frame_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_parser_top
// Parses reader bytes into a six-byte tag frame with XOR checksum check.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall with i_mode and i_rx_byte. Mode 0 carries a
// received byte, mode 1 releases a held tag and clears the parser.
// Output channel: o_valid/i_stall with o_tag_ready, o_tag_bytes and
// o_running_xor; exactly one result per input item, showing the parser state
// after that item.
// Path: an accepted item is first held in the input register, then its state
// update lands in the result register.
// Throughput: one item per cycle unless the receiver stalls; each byte update
// is one pass of compare/XOR logic between the input and state registers.
// Reset (i_rst_n low, synchronous) empties both stages, returns the parser to
// hunt and clears the tag store, XOR and digit count.
// When the receiver stalls, the result register holds and the held input item
// waits in the input register; o_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfid_ascii_hex_frame_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tag_ready,
    output logic [47:0]      o_tag_bytes,
    output logic [7:0]       o_running_xor
);

    // input stage
    logic       r_in_valid;
    logic       r_mode;
    logic [7:0] r_byte;

    // parser state
    rfid_pkg::t_phase r_phase,       n_phase;
    logic [3:0]       r_digit_count, n_digit_count;
    logic [3:0]       r_held_nibble, n_held_nibble;
    logic [7:0]       r_tag_store [rfid_pkg::TAG_BYTES];
    logic [7:0]       n_tag_store [rfid_pkg::TAG_BYTES];
    logic [7:0]       r_xor_accum,   n_xor_accum;

    // result stage
    logic        r_out_valid;
    logic        r_tag_ready;
    logic [47:0] r_tag_bytes;
    logic [7:0]  r_running_xor;

    logic        advance;
    logic        process;
    logic        in_accept;
    logic [7:0]  digit;
    logic [7:0]  assembled;
    logic [2:0]  slot;
    logic [3:0]  count_inc;
    logic        abort_byte;
    logic [47:0] packed_store;

    assign advance   = !r_out_valid || !i_stall;
    assign process   = r_in_valid && advance;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    assign o_valid       = r_out_valid;
    assign o_tag_ready   = r_tag_ready;
    assign o_tag_bytes   = r_tag_bytes;
    assign o_running_xor = r_running_xor;

    always_comb begin
        // non-hex bytes go through raw
        if (r_byte inside {[rfid_pkg::ASC_0:rfid_pkg::ASC_9]}) begin
            digit = r_byte - rfid_pkg::ASC_0;
        end else if (r_byte inside {[rfid_pkg::ASC_A:rfid_pkg::ASC_F]}) begin
            digit = r_byte - rfid_pkg::ASC_A + 8'd10;
        end else begin
            digit = r_byte;
        end
    end

    assign assembled  = digit | {r_held_nibble, 4'h0};
    assign slot       = r_digit_count[3:1];
    assign count_inc  = r_digit_count + 4'd1;
    assign abort_byte = (r_byte == rfid_pkg::BYTE_CR) || (r_byte == rfid_pkg::BYTE_LF)
                     || (r_byte == rfid_pkg::BYTE_ETX) || (r_byte == rfid_pkg::BYTE_STX);

    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_held_nibble = r_held_nibble;
        n_xor_accum   = r_xor_accum;
        n_tag_store   = r_tag_store;
        if (process) begin
            if (r_mode || (r_phase == rfid_pkg::PH_HUNT)) begin
                n_phase       = rfid_pkg::PH_HUNT;
                n_digit_count = 4'd0;
                n_held_nibble = 4'd0;
                n_xor_accum   = 8'd0;
                for (int i = 0; i < rfid_pkg::TAG_BYTES; i++) begin
                    n_tag_store[i] = 8'd0;
                end
                if (!r_mode && (r_byte == rfid_pkg::BYTE_STX)) begin
                    n_phase = rfid_pkg::PH_COLLECT;
                end
            end else if (r_phase == rfid_pkg::PH_COLLECT) begin
                if (abort_byte) begin
                    // store and XOR survive until the next byte in hunt
                    n_phase = rfid_pkg::PH_HUNT;
                end else begin
                    if (r_digit_count[0]) begin
                        n_tag_store[slot] = assembled;
                        if (slot != rfid_pkg::CHECK_INDEX) begin
                            n_xor_accum = r_xor_accum ^ assembled;
                        end
                    end else begin
                        n_held_nibble = digit[3:0];
                    end
                    n_digit_count = count_inc;
                    if (count_inc >= rfid_pkg::FRAME_DIGITS) begin
                        n_phase = (n_tag_store[rfid_pkg::CHECK_INDEX] == n_xor_accum)
                                ? rfid_pkg::PH_HOLD : rfid_pkg::PH_HUNT;
                    end
                end
            end
            // hold ignores bytes until a release
        end
    end

    always_comb begin
        packed_store = '0;
        for (int i = 0; i < rfid_pkg::TAG_BYTES; i++) begin
            packed_store[(rfid_pkg::TAG_BYTES - 1 - i) * 8 +: 8] = n_tag_store[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rfid_pkg::PH_HUNT;
            r_digit_count <= 4'd0;
            r_held_nibble <= 4'd0;
            r_xor_accum   <= 8'd0;
            for (int i = 0; i < rfid_pkg::TAG_BYTES; i++) begin
                r_tag_store[i] <= 8'd0;
            end
        end else begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_held_nibble <= n_held_nibble;
            r_xor_accum   <= n_xor_accum;
            r_tag_store   <= n_tag_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_tag_ready   <= (n_phase == rfid_pkg::PH_HOLD);
            r_tag_bytes   <= packed_store;
            r_running_xor <= n_xor_accum;
        end
    end

    // a held tag always carries a matching checksum byte
    `ASSERT_IMPL(a_ready_checksum, i_clk, i_rst_n, r_out_valid && r_tag_ready,
                 r_tag_bytes[7:0] == r_running_xor)

    // collect never sits on a full frame count
    `ASSERT_IMPL(a_collect_count, i_clk, i_rst_n, r_phase == rfid_pkg::PH_COLLECT,
                 r_digit_count < rfid_pkg::FRAME_DIGITS)

    // only a release leaves hold
    `ASSERT_NEXT(a_hold_sticky, i_clk, i_rst_n,
                 process && !r_mode && (r_phase == rfid_pkg::PH_HOLD),
                 r_phase == rfid_pkg::PH_HOLD)

    // a stalled result never lets the state move
    `ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, o_stall,
                 $stable(r_xor_accum) && $stable(r_digit_count))

endmodule
`default_nettype wire

### tb/rfid_ascii_hex_frame_parser_top_test.sv
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_parser_top_test
// Drives reader byte streams into the tag frame parser and checks every
// result against a cycle-free parser model or a typed row's own view. A
// short table covers release, byte extremes, a good frame, hold, aborts
// and raw bytes. Random frames with mostly valid checksums, corrupted digits
// and noise follow, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module rfid_ascii_hex_frame_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam int QUIET_TAIL_START = 1150;
    localparam int LAST_ITEM        = 1300;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct packed {
        logic        ready;
        logic [47:0] tag;
        logic [7:0]  xsum;
    } t_parser_view;

    typedef struct packed {
        logic         mode_bit;
        logic [7:0]   rx;
        logic         typed;
        t_parser_view want;
    } t_stim_row;

    localparam t_parser_view VIEW_CLEAR = '{1'b0, 48'h0, 8'h00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_mode;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_tag_ready;
    logic [47:0] o_tag_bytes;
    logic [7:0]  o_running_xor;

    rfid_ascii_hex_frame_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tag_ready   (o_tag_ready),
        .o_tag_bytes   (o_tag_bytes),
        .o_running_xor (o_running_xor)
    );

    // parser model state
    rfid_pkg::t_phase parse_phase;
    logic [3:0]       digit_total;
    logic [3:0]       high_nibble;
    logic [7:0]       held_bytes [6];
    logic [7:0]       xor_sum;

    t_parser_view tag_views_due [$];
    int           n_mismatch;
    int           n_sent;
    logic         idle_on;
    int           stall_left;

    t_stim_row directed_rows [26] = '{
        '{MODE_RELEASE, 8'hFF,              1'b1, VIEW_CLEAR},
        '{MODE_BYTE,    8'hFF,              1'b1, VIEW_CLEAR},
        '{MODE_BYTE,    rfid_pkg::BYTE_STX, 1'b1, VIEW_CLEAR},
        '{MODE_BYTE,    "0",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "A",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "1",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "B",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "2",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "C",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "3",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "D",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "4",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "E",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "4",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "E",                1'b1, '{1'b1, 48'h0A1B2C3D4E4E, 8'h4E}},
        // bytes in hold are ignored
        '{MODE_BYTE,    rfid_pkg::BYTE_STX, 1'b1, '{1'b1, 48'h0A1B2C3D4E4E, 8'h4E}},
        '{MODE_RELEASE, 8'h00,              1'b1, VIEW_CLEAR},
        '{MODE_BYTE,    rfid_pkg::BYTE_STX, 1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "9",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "F",                1'b0, VIEW_CLEAR},
        // abort keeps the store until the next byte
        '{MODE_BYTE,    rfid_pkg::BYTE_LF,  1'b1, '{1'b0, 48'h9F0000000000, 8'h9F}},
        '{MODE_BYTE,    "x",                1'b1, VIEW_CLEAR},
        '{MODE_BYTE,    rfid_pkg::BYTE_STX, 1'b0, VIEW_CLEAR},
        // non-hex bytes go in raw
        '{MODE_BYTE,    8'hFF,              1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    "a",                1'b0, VIEW_CLEAR},
        '{MODE_BYTE,    rfid_pkg::BYTE_ETX, 1'b1, '{1'b0, 48'hF10000000000, 8'hF1}}
    };

    logic [7:0] abort_codes [4] = '{rfid_pkg::BYTE_CR, rfid_pkg::BYTE_LF,
                                    rfid_pkg::BYTE_ETX, rfid_pkg::BYTE_STX};

    function automatic void clear_parser();
        for (int s = 0; s < rfid_pkg::TAG_BYTES; s++) begin
            held_bytes[s] = 8'h00;
        end
        xor_sum     = 8'h00;
        digit_total = 4'd0;
        high_nibble = 4'd0;
        parse_phase = rfid_pkg::PH_HUNT;
    endfunction

    function automatic t_parser_view advance_parser(input logic mode_bit, input logic [7:0] rx);
        t_parser_view view;
        logic [7:0]   digit;
        logic [2:0]   slot;
        if (mode_bit == MODE_RELEASE) begin
            clear_parser();
        end else if (parse_phase == rfid_pkg::PH_HUNT) begin
            clear_parser();
            if (rx == rfid_pkg::BYTE_STX) begin
                parse_phase = rfid_pkg::PH_COLLECT;
            end
        end else if (parse_phase == rfid_pkg::PH_COLLECT) begin
            if (rx == rfid_pkg::BYTE_CR || rx == rfid_pkg::BYTE_LF
                || rx == rfid_pkg::BYTE_ETX || rx == rfid_pkg::BYTE_STX) begin
                parse_phase = rfid_pkg::PH_HUNT;
            end else begin
                if (rx >= rfid_pkg::ASC_0 && rx <= rfid_pkg::ASC_9) begin
                    digit = rx - rfid_pkg::ASC_0;
                end else if (rx >= rfid_pkg::ASC_A && rx <= rfid_pkg::ASC_F) begin
                    digit = rx - rfid_pkg::ASC_A + 8'd10;
                end else begin
                    digit = rx;
                end
                slot = digit_total[3:1];
                if (digit_total[0]) begin
                    held_bytes[slot] = digit | {high_nibble, 4'h0};
                    if (slot != rfid_pkg::CHECK_INDEX) begin
                        xor_sum = xor_sum ^ held_bytes[slot];
                    end
                end else begin
                    high_nibble = digit[3:0];
                end
                digit_total = digit_total + 4'd1;
                if (digit_total >= rfid_pkg::FRAME_DIGITS) begin
                    if (held_bytes[rfid_pkg::CHECK_INDEX] == xor_sum) begin
                        parse_phase = rfid_pkg::PH_HOLD;
                    end else begin
                        parse_phase = rfid_pkg::PH_HUNT;
                    end
                end
            end
        end
        view.ready = (parse_phase == rfid_pkg::PH_HOLD);
        view.tag   = {held_bytes[0], held_bytes[1], held_bytes[2],
                      held_bytes[3], held_bytes[4], held_bytes[5]};
        view.xsum  = xor_sum;
        return view;
    endfunction

    // Presents one item, waits for it to be taken, then queues its expected view.
    task automatic drive_item(input logic mode_bit, input logic [7:0] rx, input logic typed,
                              input t_parser_view want);
        t_parser_view predicted;
        int           gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_mode    <= mode_bit;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        predicted = advance_parser(mode_bit, rx);
        tag_views_due.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_parser_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tag_views_due.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected result: ready=%0b tag=%h xor=%h", $time,
                         o_tag_ready, o_tag_bytes, o_running_xor);
            end else begin
                want = tag_views_due.pop_front();
                if (o_tag_ready !== want.ready) begin
                    n_mismatch++;
                    $display("%0t: tag_ready expected %0b actual %0b", $time,
                             want.ready, o_tag_ready);
                end
                if (o_tag_bytes !== want.tag) begin
                    n_mismatch++;
                    $display("%0t: tag_bytes expected %h actual %h", $time,
                             want.tag, o_tag_bytes);
                end
                if (o_running_xor !== want.xsum) begin
                    n_mismatch++;
                    $display("%0t: running_xor expected %h actual %h", $time,
                             want.xsum, o_running_xor);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [7:0] frame [6];
        logic [3:0] nib;
        logic [7:0] ch;
        logic       quiet;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_mode     = MODE_BYTE;
        i_rx_byte  = 8'h00;
        i_stall    = 1'b0;
        stall_left = 0;
        idle_on    = 1'b0;
        n_mismatch = 0;
        n_sent     = 0;
        clear_parser();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        foreach (directed_rows[r]) begin
            drive_item(directed_rows[r].mode_bit, directed_rows[r].rx,
                       directed_rows[r].typed, directed_rows[r].want);
        end

        while (n_sent < LAST_ITEM) begin
            quiet   = ($urandom_range(0, 4) == 0);
            idle_on = !quiet && (n_sent < QUIET_TAIL_START);
            if ($urandom_range(0, 3) != 0) begin
                // frame with random tag, checksum right most of the time
                frame[5] = 8'h00;
                for (int b = 0; b < 5; b++) begin
                    frame[b] = 8'($urandom_range(0, 255));
                    frame[5] = frame[5] ^ frame[b];
                end
                if ($urandom_range(0, 3) == 0) begin
                    frame[5] = 8'($urandom_range(0, 255));
                end
                drive_item(MODE_BYTE, rfid_pkg::BYTE_STX, 1'b0, VIEW_CLEAR);
                for (int d = 0; d < 12; d++) begin
                    nib = d[0] ? frame[d / 2][3:0] : frame[d / 2][7:4];
                    ch  = (nib < 4'd10) ? rfid_pkg::ASC_0 + {4'h0, nib}
                                        : rfid_pkg::ASC_A + {4'h0, nib} - 8'd10;
                    case ($urandom_range(0, 79))
                        0: drive_item(MODE_RELEASE, ch, 1'b0, VIEW_CLEAR);
                        1: drive_item(MODE_BYTE, abort_codes[2'($urandom_range(0, 3))], 1'b0,
                                      VIEW_CLEAR);
                        2: drive_item(MODE_BYTE, 8'($urandom_range(0, 255)), 1'b0, VIEW_CLEAR);
                        default: drive_item(MODE_BYTE, ch, 1'b0, VIEW_CLEAR);
                    endcase
                end
                repeat ($urandom_range(0, 2)) begin
                    drive_item(MODE_BYTE, 8'($urandom_range(0, 255)), 1'b0, VIEW_CLEAR);
                end
                if ($urandom_range(0, 9) != 0) begin
                    drive_item(MODE_RELEASE, 8'($urandom_range(0, 255)), 1'b0, VIEW_CLEAR);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    drive_item(($urandom_range(0, 7) == 0) ? MODE_RELEASE : MODE_BYTE,
                               8'($urandom_range(0, 255)), 1'b0, VIEW_CLEAR);
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        idle_on = 1'b0;
        while (tag_views_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
